[src/lcdw_pkg.sv]
package lcdw_pkg;

  // Request codes carried by the action field
  localparam logic [1:0] ActTick      = 2'd0;
  localparam logic [1:0] ActCommand   = 2'd1;
  localparam logic [1:0] ActCharacter = 2'd2;
  localparam logic [1:0] ActCursor    = 2'd3;

  // Configuration register indexes
  localparam logic CfgDevAddr    = 1'b0;
  localparam logic CfgAckTimeout = 1'b1;

  // Register reset values
  localparam logic [7:0] DevAddrReset    = 8'h7C;
  localparam logic [7:0] AckTimeoutReset = 8'd200;

  // Control bytes that follow the address byte
  localparam logic [7:0] CmdCtrl  = 8'h80;
  localparam logic [7:0] DataCtrl = 8'h40;

  // Display geometry
  localparam int DefaultColumns = 16;
  localparam int LcdRows        = 2;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
    logic [3:0] column;
    logic       row;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic scl;
    logic sda_out;
    logic busy;
    logic ack_missed;
    logic done;
    logic dropped;
  } result_t;

  typedef struct packed {
    logic [7:0] dev_addr;
    logic [7:0] ack_timeout;
  } cfg_t;

endpackage

[src/lcdw_cfg_regs.sv]
module lcdw_cfg_regs
  import lcdw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i,
  output cfg_t       cfg_o
);

  logic [7:0] dev_addr_q;
  logic [7:0] ack_timeout_q;

  // Accept a write on every cycle
  assign cfg_ready_o = 1'b1;

  // Store the addressed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q    <= DevAddrReset;
      ack_timeout_q <= AckTimeoutReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgDevAddr:    dev_addr_q    <= cfg_data_i;
        CfgAckTimeout: ack_timeout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o.dev_addr    = dev_addr_q;
  assign cfg_o.ack_timeout = ack_timeout_q;

endmodule

[src/lcdw_engine.sv]
module lcdw_engine
  import lcdw_pkg::*;
#(
  parameter int COLUMNS = DefaultColumns
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  localparam int ColW = $clog2(COLUMNS);
  localparam int CmpW = 7;

  // Bus phase codes
  localparam logic [3:0] PhIdle = 4'd0;
  localparam logic [3:0] PhSt0  = 4'd1;
  localparam logic [3:0] PhSt1  = 4'd2;
  localparam logic [3:0] PhSt2  = 4'd3;
  localparam logic [3:0] PhBd   = 4'd4;
  localparam logic [3:0] PhBh   = 4'd5;
  localparam logic [3:0] PhBf   = 4'd6;
  localparam logic [3:0] PhAl   = 4'd7;
  localparam logic [3:0] PhAh   = 4'd8;
  localparam logic [3:0] PhAf   = 4'd9;
  localparam logic [3:0] PhSp0  = 4'd10;
  localparam logic [3:0] PhSp1  = 4'd11;
  localparam logic [3:0] PhSp2  = 4'd12;

  logic [3:0]      phase_q, phase_d, phase_eff;
  logic [3:0]      bit_cnt_q, bit_cnt_d;
  logic [2:0]      byte_idx_q, byte_idx_d, byte_idx_inc;
  logic [7:0]      shift_q, shift_d;
  logic [7:0]      pend_cmd_q, pend_cmd_d;
  logic [7:0]      pend_char_q, pend_char_d;
  logic [7:0]      ack_cnt_q, ack_cnt_d;
  logic [ColW-1:0] col_q, col_d;
  logic            row_q, row_d;
  logic [1:0]      kind_q, kind_d;
  logic            start;
  logic [CmpW-1:0] col_ext;
  logic [8:0]      ack_next;
  logic [3:0]      bit_cnt_inc;
  result_t         res;

  // Pick the byte that a frame position sends
  function automatic logic [7:0] frame_byte(input logic [2:0] idx, input logic [7:0] addr,
                                            input logic [7:0] cmd, input logic [7:0] chr);
    logic [7:0] b;
    unique case (idx)
      3'd0, 3'd3: b = addr;
      3'd1:       b = CmdCtrl;
      3'd2:       b = cmd;
      3'd4:       b = DataCtrl;
      default:    b = chr;
    endcase
    return b;
  endfunction

  assign col_ext      = CmpW'(item_i.column);
  assign ack_next     = {1'b0, ack_cnt_q} + 9'd1;
  assign bit_cnt_inc  = bit_cnt_q + 4'd1;
  assign byte_idx_inc = byte_idx_q + 3'd1;
  assign start        = (phase_q == PhIdle) &&
                        ((item_i.action == ActCommand) || (item_i.action == ActCharacter));
  assign phase_eff    = start ? PhSt0 : phase_q;

  // Take the request, then run one bus phase
  always_comb begin
    phase_d     = phase_q;
    bit_cnt_d   = bit_cnt_q;
    byte_idx_d  = byte_idx_q;
    shift_d     = shift_q;
    pend_cmd_d  = pend_cmd_q;
    pend_char_d = pend_char_q;
    ack_cnt_d   = ack_cnt_q;
    col_d       = col_q;
    row_d       = row_q;
    kind_d      = kind_q;
    res         = '{scl: 1'b1, sda_out: 1'b1, busy: 1'b0, ack_missed: 1'b0,
                    done: 1'b0, dropped: 1'b0};

    if (item_i.action != ActTick) begin
      if (phase_q != PhIdle) begin
        res.dropped = 1'b1;
      end else if (item_i.action == ActCursor) begin
        col_d    = ColW'((col_ext >= CmpW'(COLUMNS)) ? col_ext - CmpW'(COLUMNS) : col_ext);
        row_d    = (LcdRows == 1) ? 1'b0 : item_i.row;
        res.done = 1'b1;
      end else begin
        kind_d     = item_i.action;
        byte_idx_d = 3'd0;
        if (item_i.action == ActCommand) begin
          pend_cmd_d = item_i.data_byte;
        end else begin
          pend_cmd_d  = CmdCtrl | {1'b0, row_q, 6'(col_q)};
          pend_char_d = item_i.data_byte;
        end
      end
    end

    res.busy = (phase_eff != PhIdle);
    unique case (phase_eff)
      PhIdle: ;
      PhSt0: begin
        phase_d = PhSt1;
      end
      PhSt1: begin
        res.sda_out = 1'b0;
        phase_d     = PhSt2;
      end
      PhSt2: begin
        res.scl     = 1'b0;
        res.sda_out = 1'b0;
        shift_d     = frame_byte(byte_idx_q, cfg_i.dev_addr, pend_cmd_q, pend_char_q);
        bit_cnt_d   = 4'd0;
        phase_d     = PhBd;
      end
      PhBd: begin
        res.scl     = 1'b0;
        res.sda_out = shift_q[7];
        phase_d     = PhBh;
      end
      PhBh: begin
        res.sda_out = shift_q[7];
        phase_d     = PhBf;
      end
      PhBf: begin
        res.scl     = 1'b0;
        res.sda_out = shift_q[7];
        shift_d     = {shift_q[6:0], 1'b0};
        bit_cnt_d   = bit_cnt_inc;
        phase_d     = (bit_cnt_inc >= 4'd8) ? PhAl : PhBd;
      end
      PhAl: begin
        res.scl   = 1'b0;
        ack_cnt_d = 8'd0;
        phase_d   = PhAh;
      end
      PhAh: begin
        if (!item_i.sda_in) begin
          phase_d = PhAf;
        end else if (ack_next >= {1'b0, cfg_i.ack_timeout}) begin
          res.ack_missed = 1'b1;
          phase_d        = PhAf;
        end else begin
          ack_cnt_d = ack_next[7:0];
        end
      end
      PhAf: begin
        res.scl    = 1'b0;
        byte_idx_d = byte_idx_inc;
        if ((byte_idx_inc == 3'd3) || (byte_idx_inc >= 3'd6)) begin
          phase_d = PhSp0;
        end else begin
          shift_d   = frame_byte(byte_idx_inc, cfg_i.dev_addr, pend_cmd_q, pend_char_q);
          bit_cnt_d = 4'd0;
          phase_d   = PhBd;
        end
      end
      PhSp0: begin
        res.scl     = 1'b0;
        res.sda_out = 1'b0;
        phase_d     = PhSp1;
      end
      PhSp1: begin
        res.sda_out = 1'b0;
        phase_d     = PhSp2;
      end
      PhSp2: begin
        if ((kind_q == ActCharacter) && (byte_idx_q == 3'd3)) begin
          phase_d = PhSt0;
        end else begin
          // Advance the cursor after a character, wrapping to the next row
          if (kind_q == ActCharacter) begin
            if (col_q == ColW'(COLUMNS - 1)) begin
              col_d = '0;
              row_d = (LcdRows == 1) ? 1'b0 : ~row_q;
            end else begin
              col_d = col_q + 1'b1;
            end
          end
          res.done = 1'b1;
          phase_d  = PhIdle;
        end
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase
  end

  // Commit the state on each stepped item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      bit_cnt_q   <= '0;
      byte_idx_q  <= '0;
      shift_q     <= '0;
      pend_cmd_q  <= '0;
      pend_char_q <= '0;
      ack_cnt_q   <= '0;
      col_q       <= '0;
      row_q       <= 1'b0;
      kind_q      <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      bit_cnt_q   <= bit_cnt_d;
      byte_idx_q  <= byte_idx_d;
      shift_q     <= shift_d;
      pend_cmd_q  <= pend_cmd_d;
      pend_char_q <= pend_char_d;
      ack_cnt_q   <= ack_cnt_d;
      col_q       <= col_d;
      row_q       <= row_d;
      kind_q      <= kind_d;
    end
  end

  assign res_o = res;

endmodule

[src/i2c_character_lcd_writer_core.sv]
// Character LCD writer over a bit-banged I2C master. Every input transaction is
// one bus phase tick and yields exactly one result transaction with the SCL and
// SDA levels for that tick plus busy, ACK-miss, done and dropped-request flags.
// One transaction is taken per clock cycle while the result register is free or
// being taken; a result that waits holds back the input. A result is loaded into
// the result register after its input has passed the input register (input register,
// then result register), and the engine updates its phase on each stepped item. Configuration
// writes are taken on every cycle and must only be issued while no request is in flight.
module i2c_character_lcd_writer_core
  import lcdw_pkg::*;
#(
  parameter int COLUMNS = DefaultColumns
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] action_i,
  input  logic [7:0] data_byte_i,
  input  logic [3:0] column_i,
  input  logic       row_i,
  input  logic       sda_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       scl_o,
  output logic       sda_out_o,
  output logic       busy_res_o,
  output logic       ack_missed_o,
  output logic       done_res_o,
  output logic       request_dropped_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  logic    in_valid_q;
  item_t   in_item_q;
  logic    out_valid_q;
  result_t out_res_q;
  logic    step;
  result_t res;
  cfg_t    cfg;

  // Advance the held item when the result register is free or being taken
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  lcdw_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lcdw_engine #(
    .COLUMNS (COLUMNS)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Hold the input transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= '{action: action_i, data_byte: data_byte_i, column: column_i,
                     row: row_i, sda_in: sda_in_i};
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign scl_o             = out_res_q.scl;
  assign sda_out_o         = out_res_q.sda_out;
  assign busy_res_o        = out_res_q.busy;
  assign ack_missed_o      = out_res_q.ack_missed;
  assign done_res_o        = out_res_q.done;
  assign request_dropped_o = out_res_q.dropped;

  // A stepped item always lands in the result register
  a_step_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("stepped item did not reach the result register");

  // A dropped request only happens while a transfer runs
  a_drop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.dropped) |-> out_res_q.busy)
    else $error("request dropped while idle");

  // An ACK miss is flagged with SCL high and SDA released
  a_miss_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.ack_missed) |-> (out_res_q.busy && out_res_q.scl &&
                                                out_res_q.sda_out))
    else $error("ACK miss outside the ACK slot");

  // An idle bus keeps both lines released
  a_idle_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_res_q.busy) |-> (out_res_q.scl && out_res_q.sda_out))
    else $error("idle bus drives a line low");

endmodule

[sim/tb_i2c_character_lcd_writer_core.sv]
module tb_i2c_character_lcd_writer_core;
  import lcdw_pkg::*;

  // Bus phases of the predictor's bit engine
  typedef enum logic [3:0] {
    PhIdle, PhStart0, PhStart1, PhStart2, PhBitSetup, PhBitHigh, PhBitFall,
    PhAckLow, PhAckHigh, PhAckFall, PhStop0, PhStop1, PhStop2
  } bus_phase_e;

  // Set-DDRAM-address command and the offset of the second display row
  localparam logic [7:0] SetDdramAddr = 8'h80;
  localparam logic [7:0] RowTwoOffset = 8'h40;

  // One row of the directed table
  typedef struct packed {
    item_t   stim;
    logic    typed;
    result_t want;
    logic    settle;
  } dir_row_t;
  localparam int DirRows = 14;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [1:0] action_i = ActTick;
  logic [7:0] data_byte_i = 8'h00;
  logic [3:0] column_i = 4'h0;
  logic       row_i = 1'b0;
  logic       sda_in_i = 1'b1;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       scl_o;
  logic       sda_out_o;
  logic       busy_res_o;
  logic       ack_missed_o;
  logic       done_res_o;
  logic       request_dropped_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_index_i = CfgDevAddr;
  logic [7:0] cfg_data_i = 8'h00;

  i2c_character_lcd_writer_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .action_i          (action_i),
    .data_byte_i       (data_byte_i),
    .column_i          (column_i),
    .row_i             (row_i),
    .sda_in_i          (sda_in_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .scl_o             (scl_o),
    .sda_out_o         (sda_out_o),
    .busy_res_o        (busy_res_o),
    .ack_missed_o      (ack_missed_o),
    .done_res_o        (done_res_o),
    .request_dropped_o (request_dropped_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: registers, bit engine and cursor
  logic [7:0] dev_addr  = DevAddrReset;
  logic [7:0] ack_limit = AckTimeoutReset;
  bus_phase_e ph        = PhIdle;
  logic [3:0] bit_cnt   = '0;
  logic [2:0] byte_idx  = '0;
  logic [7:0] shreg     = '0;
  logic [7:0] pend_cmd  = '0;
  logic [7:0] pend_chr  = '0;
  logic [7:0] ack_cnt   = '0;
  logic [3:0] cur_col   = '0;
  logic       cur_row   = 1'b0;
  logic [1:0] req_kind  = ActTick;

  // Expected bus levels and flags, oldest first
  result_t bus_levels_q[$];

  int err_count   = 0;
  int n_items     = 0;
  int n_checked   = 0;
  int n_done      = 0;
  int n_missed    = 0;
  int n_dropped   = 0;
  int n_settings  = 1;
  int burst_left  = 0;
  int ack_low_pct = 85;
  int ready_mode  = 0;
  int ready_left  = 0;

  task automatic flag_error(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    err_count++;
  endtask

  // Load the next byte of the current frame into the shifter
  task automatic load_frame_byte();
    case (byte_idx)
      3'd0, 3'd3: shreg = dev_addr;
      3'd1:       shreg = CmdCtrl;
      3'd2:       shreg = pend_cmd;
      3'd4:       shreg = DataCtrl;
      default:    shreg = pend_chr;
    endcase
    bit_cnt = '0;
    ph = PhBitSetup;
  endtask

  // Advance the predictor by one bus tick and return the levels for it
  task automatic lcd_bus_tick(input item_t it, output result_t r);
    int wait_next;
    r = '0;
    r.scl = 1'b1;
    r.sda_out = 1'b1;
    if (it.action != ActTick) begin
      if (ph != PhIdle) begin
        r.dropped = 1'b1;
      end else if (it.action == ActCursor) begin
        cur_col = 4'(it.column % DefaultColumns);
        cur_row = 1'(it.row % LcdRows);
        r.done = 1'b1;
      end else begin
        req_kind = it.action;
        if (it.action == ActCommand) begin
          pend_cmd = it.data_byte;
        end else begin
          pend_cmd = SetDdramAddr | (cur_row ? RowTwoOffset : 8'h00) | {4'h0, cur_col};
          pend_chr = it.data_byte;
        end
        byte_idx = '0;
        ph = PhStart0;
      end
    end
    r.busy = (ph != PhIdle);
    case (ph)
      PhStart0: begin
        ph = PhStart1;
      end
      PhStart1: begin
        r.sda_out = 1'b0;
        ph = PhStart2;
      end
      PhStart2: begin
        r.scl = 1'b0;
        r.sda_out = 1'b0;
        load_frame_byte();
      end
      PhBitSetup: begin
        r.scl = 1'b0;
        r.sda_out = shreg[7];
        ph = PhBitHigh;
      end
      PhBitHigh: begin
        r.sda_out = shreg[7];
        ph = PhBitFall;
      end
      PhBitFall: begin
        r.scl = 1'b0;
        r.sda_out = shreg[7];
        shreg = {shreg[6:0], 1'b0};
        bit_cnt = bit_cnt + 4'd1;
        ph = (bit_cnt >= 4'd8) ? PhAckLow : PhBitSetup;
      end
      PhAckLow: begin
        r.scl = 1'b0;
        ack_cnt = '0;
        ph = PhAckHigh;
      end
      PhAckHigh: begin
        // Release SDA and wait for the slave to pull it low or time out
        if (!it.sda_in) begin
          ph = PhAckFall;
        end else begin
          wait_next = int'(ack_cnt) + 1;
          if (wait_next >= int'(ack_limit)) begin
            r.ack_missed = 1'b1;
            ph = PhAckFall;
          end else begin
            ack_cnt = 8'(wait_next);
          end
        end
      end
      PhAckFall: begin
        r.scl = 1'b0;
        byte_idx = byte_idx + 3'd1;
        if (byte_idx == 3'd3 || byte_idx >= 3'd6) ph = PhStop0;
        else load_frame_byte();
      end
      PhStop0: begin
        r.scl = 1'b0;
        r.sda_out = 1'b0;
        ph = PhStop1;
      end
      PhStop1: begin
        r.sda_out = 1'b0;
        ph = PhStop2;
      end
      PhStop2: begin
        // A character goes on to its data frame; otherwise finish the request
        if (req_kind == ActCharacter && byte_idx == 3'd3) begin
          ph = PhStart0;
        end else begin
          if (req_kind == ActCharacter) begin
            if (int'(cur_col) + 1 >= DefaultColumns) begin
              cur_col = '0;
              cur_row = 1'((int'(cur_row) + 1) % LcdRows);
            end else begin
              cur_col = cur_col + 4'd1;
            end
          end
          r.done = 1'b1;
          ph = PhIdle;
        end
      end
      default: begin
        ph = PhIdle;
      end
    endcase
  endtask

  // Offer one input transaction, predict its result once taken, then maybe pause
  task automatic push_item(input item_t it, input logic typed, input result_t typed_want);
    result_t want;
    int gap;
    in_valid_i  <= 1'b1;
    action_i    <= it.action;
    data_byte_i <= it.data_byte;
    column_i    <= it.column;
    row_i       <= it.row;
    sda_in_i    <= it.sda_in;
    do @(posedge clk_i); while (!in_ready_o);
    lcd_bus_tick(it, want);
    if (typed) want = typed_want;
    bus_levels_q.push_back(want);
    n_items++;
    n_done    += want.done;
    n_missed  += want.ack_missed;
    n_dropped += want.dropped;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(3) == 0) ? $urandom_range(12, 5) : $urandom_range(3);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(80, 30) : $urandom_range(10, 1);
    end
  endtask

  // Drop valid and hold until every predicted result has been taken
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (bus_levels_q.size() != 0);
  endtask

  // Random tick: requests when idle, mostly plain ticks with a few drops when busy
  task automatic random_item(output item_t it);
    int pick;
    it.data_byte = 8'($urandom);
    it.column    = 4'($urandom);
    it.row       = 1'($urandom);
    it.sda_in    = 1'($urandom);
    pick = $urandom_range(99);
    if (ph == PhIdle) begin
      if (pick < 10)      it.action = ActTick;
      else if (pick < 45) it.action = ActCharacter;
      else if (pick < 75) it.action = ActCommand;
      else                it.action = ActCursor;
    end else begin
      it.action = (pick < 6) ? 2'($urandom_range(3, 1)) : ActTick;
    end
    if (ph == PhAckHigh) it.sda_in = ($urandom_range(99) >= ack_low_pct);
  endtask

  // Tick the bus until the request in flight is over, then let the block go quiet
  task automatic finish_transfer();
    item_t it;
    while (ph != PhIdle) begin
      random_item(it);
      it.action = ActTick;
      push_item(it, 1'b0, '0);
    end
    hold_until_drained();
    repeat (4) @(posedge clk_i);
  endtask

  // Write both registers back to back while the block is idle
  task automatic write_settings(input logic [7:0] addr, input logic [7:0] tmo);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgDevAddr;
    cfg_data_i  <= addr;
    do @(posedge clk_i); while (!cfg_ready_o);
    dev_addr = addr;
    cfg_index_i <= CfgAckTimeout;
    cfg_data_i  <= tmo;
    do @(posedge clk_i); while (!cfg_ready_o);
    ack_limit = tmo;
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  // Directed table: stimulus {action, data, column, row, sda}, typed flag,
  // expected {scl, sda, busy, missed, done, dropped}, settle flag
  function automatic dir_row_t dir_row(input int n);
    case (n)
      // idle tick right after reset
      0:  dir_row = {ActTick,      8'h00, 4'h0, 1'b0, 1'b1, 1'b1, 6'b110000, 1'b0};
      // set cursor to the last cell while idle
      1:  dir_row = {ActCursor,    8'h00, 4'hF, 1'b1, 1'b0, 1'b1, 6'b110010, 1'b0};
      2:  dir_row = {ActTick,      8'hFF, 4'hF, 1'b1, 1'b1, 1'b1, 6'b110000, 1'b0};
      // character starts a transaction on the same tick
      3:  dir_row = {ActCharacter, 8'hFF, 4'h0, 1'b0, 1'b1, 1'b1, 6'b111000, 1'b0};
      // every request kind while busy is dropped
      4:  dir_row = {ActCommand,   8'h00, 4'h0, 1'b0, 1'b1, 1'b1, 6'b101001, 1'b0};
      5:  dir_row = {ActCursor,    8'h00, 4'h5, 1'b0, 1'b1, 1'b1, 6'b001001, 1'b0};
      6:  dir_row = {ActCharacter, 8'h55, 4'h0, 1'b0, 1'b0, 1'b1, 6'b001001, 1'b1};
      // command bytes at both extremes
      7:  dir_row = {ActCommand,   8'h00, 4'h0, 1'b0, 1'b0, 1'b1, 6'b111000, 1'b1};
      8:  dir_row = {ActCursor,    8'h00, 4'h0, 1'b0, 1'b1, 1'b1, 6'b110010, 1'b0};
      9:  dir_row = {ActCommand,   8'hFF, 4'hA, 1'b1, 1'b0, 1'b1, 6'b111000, 1'b1};
      10: dir_row = {ActCharacter, 8'h00, 4'h0, 1'b0, 1'b1, 1'b1, 6'b111000, 1'b1};
      // wrap from the end of the first row to the second
      11: dir_row = {ActCursor,    8'h00, 4'hF, 1'b0, 1'b1, 1'b1, 6'b110010, 1'b0};
      12: dir_row = {ActCharacter, 8'h41, 4'h3, 1'b1, 1'b1, 1'b0, 6'b000000, 1'b1};
      default:
          dir_row = {ActTick,      8'h00, 4'h0, 1'b0, 1'b0, 1'b1, 6'b110000, 1'b0};
    endcase
  endfunction

  // Take results on a stall pattern of bursts, random, sparse and long holds
  always @(posedge clk_i) begin : result_check
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {scl_o, sda_out_o, busy_res_o, ack_missed_o, done_res_o, request_dropped_o};
      if (bus_levels_q.size() == 0) begin
        flag_error($sformatf("result %b with nothing expected", got));
      end else begin
        want = bus_levels_q.pop_front();
        if (got.scl !== want.scl)
          flag_error($sformatf("#%0d scl %b want %b", n_checked, got.scl, want.scl));
        if (got.sda_out !== want.sda_out)
          flag_error($sformatf("#%0d sda_out %b want %b", n_checked, got.sda_out,
                               want.sda_out));
        if (got.busy !== want.busy)
          flag_error($sformatf("#%0d busy %b want %b", n_checked, got.busy, want.busy));
        if (got.ack_missed !== want.ack_missed)
          flag_error($sformatf("#%0d ack_missed %b want %b", n_checked, got.ack_missed,
                               want.ack_missed));
        if (got.done !== want.done)
          flag_error($sformatf("#%0d done %b want %b", n_checked, got.done, want.done));
        if (got.dropped !== want.dropped)
          flag_error($sformatf("#%0d dropped %b want %b", n_checked, got.dropped,
                               want.dropped));
        n_checked++;
      end
    end
    if (ready_left == 0) begin
      ready_mode = $urandom_range(3);
      ready_left = $urandom_range(60, 8);
    end else begin
      ready_left--;
    end
    case (ready_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= 1'($urandom);
      2:       out_ready_i <= (ready_left % 4 == 0);
      default: out_ready_i <= (ready_left < 2);
    endcase
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    item_t it;
    dir_row_t dr;
    int n;
    int p;
    int k;
    logic [7:0] addr;
    logic [7:0] tmo;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed table at reset settings
    for (n = 0; n < DirRows; n++) begin
      dr = dir_row(n);
      push_item(dr.stim, dr.typed, dr.want);
      if (dr.settle) finish_transfer();
    end
    finish_transfer();

    // Random traffic over several register settings, extremes included
    for (p = 1; p <= 5; p++) begin
      case (p)
        1: begin addr = 8'h00; tmo = 8'd1; ack_low_pct = 50; end
        2: begin addr = 8'hFF; tmo = 8'd255; ack_low_pct = 85; end
        3: begin addr = 8'($urandom); tmo = 8'd0; ack_low_pct = 30; end
        4: begin addr = 8'($urandom); tmo = 8'($urandom_range(6, 2)); ack_low_pct = 45; end
        default: begin addr = DevAddrReset; tmo = AckTimeoutReset; ack_low_pct = 90; end
      endcase
      write_settings(addr, tmo);
      for (k = 0; k < 90; k++) begin
        if (k == 45) hold_until_drained();
        random_item(it);
        push_item(it, 1'b0, '0);
      end
      finish_transfer();
    end

    hold_until_drained();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d bus ticks over %0d register settings, %0d results checked.",
             n_items, n_settings, n_checked);
    $display("Saw %0d finished requests, %0d ACK misses, %0d dropped requests.",
             n_done, n_missed, n_dropped);
    if (err_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
